>>> rtl/dbwa_pkg.sv
// shared types, constants and codes for the delay based window admission block
// no dependencies; imported by every module of the block but the divider
`default_nettype none

package dbwa_pkg;

   // fixed field widths
   localparam int FIELD_BITS     = 32;
   localparam int WIN_BITS       = 32;
   localparam int FLIGHT_BITS    = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 20;
   localparam int SLO_BITS       = 20;
   localparam int SLACK_BITS     = 16;
   localparam int FLOOR_BITS     = 16;

   // parameter defaults
   localparam int TIME_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF = 16;

   // window constants, unsigned q16.16
   localparam logic [WIN_BITS-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [WIN_BITS-1:0] Q_FIFTH   = 32'd13107;
   localparam logic [WIN_BITS-1:0] WIN_RESET = 32'h0028_0000;
   localparam logic [WIN_BITS-1:0] WIN_MAX   = 32'hFFFF_FFFF;

   // register reset values
   localparam logic [SLO_BITS-1:0]   SLO_RESET   = 20'd1000;
   localparam logic [SLACK_BITS-1:0] SLACK_RESET = 16'd50;
   localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = 16'd25;
   localparam int                    TGT_RESET   = 25;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLO   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLACK = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLOOR = 2'd2;

   // item opcodes
   localparam logic OP_DISPATCH = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   typedef enum logic [1:0] {
      ST_ADMIT = 2'd0,
      ST_LATE  = 2'd1,
      ST_FULL  = 2'd2,
      ST_DONE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DIV_TGT,
      DIV_EST,
      DIV_WIN
   } div_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISP,
      S_TGT_GO,
      S_TGT_WAIT,
      S_EST_GO,
      S_EST_WAIT,
      S_WIN_GO,
      S_WIN_WAIT,
      S_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      logic        dispatch;
      logic        div_start;
      div_sel_type div_sel;
      logic        tgt_take;
      logic        est_take;
      logic        commit;
      logic        emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic win_div;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/dbwa_div.sv
// shared divide unit: restoring serial divider, one quotient bit per cycle,
// and a short shift-add divide by five; depends on nothing but its parameters
`default_nettype none

module dbwa_div #(
   parameter int NUM_BITS = 37,
   parameter int DEN_BITS = 32,
   parameter int SER_BITS = 34
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                by5,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [DEN_BITS-1:0] den,
   output logic                     done,
   output logic [NUM_BITS-1:0]      quot
);

   localparam int FIVE_STEPS = 6;
   localparam int MAX_STEPS  = (SER_BITS > FIVE_STEPS) ? SER_BITS : FIVE_STEPS;
   localparam int CNT_BITS   = $clog2(MAX_STEPS + 1);

   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                mode_ff, mode_in;
   logic [DEN_BITS:0]   shifted;
   logic [DEN_BITS:0]   diff;
   logic                fits;
   logic [7:0]          five_lo;
   logic [7:0]          rem_lo;
   logic [11:0]         fix_prod;

   // serial mode: one trial subtraction per cycle
   // by-five mode: x*3/16 grown by (1+2^-4)(1+2^-8)(1+2^-16)(1+2^-32), which
   // stays a few units low, then a small remainder fixes the last digit
   always_comb begin
      shifted  = {rem_ff, num_ff[NUM_BITS-1]};
      diff     = shifted - {1'b0, den_ff};
      fits     = shifted >= {1'b0, den_ff};
      five_lo  = {quot_ff[5:0], 2'b00} + quot_ff[7:0];
      rem_lo   = num_ff[7:0] - five_lo;
      fix_prod = {4'b0000, rem_lo} * 12'd13;
      num_in   = num_ff;
      quot_in  = quot_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      mode_in  = mode_ff;
      done_in  = 1'b0;
      if (start) begin
         mode_in = by5;
         num_in  = by5 ? num : (num << (NUM_BITS - SER_BITS));
         den_in  = den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = by5 ? CNT_BITS'(FIVE_STEPS) : CNT_BITS'(SER_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (mode_ff) begin
            case (cnt_ff)
               CNT_BITS'(6): quot_in = (num_ff >> 3) + (num_ff >> 4);
               CNT_BITS'(5): quot_in = quot_ff + (quot_ff >> 4);
               CNT_BITS'(4): quot_in = quot_ff + (quot_ff >> 8);
               CNT_BITS'(3): quot_in = quot_ff + (quot_ff >> 16);
               CNT_BITS'(2): quot_in = quot_ff + (quot_ff >> 32);
               // remainder below 64 here, (r*13)>>6 is r/5
               default:      quot_in = quot_ff + NUM_BITS'(fix_prod[11:6]);
            endcase
         end else begin
            num_in  = {num_ff[NUM_BITS-2:0], 1'b0};
            quot_in = {quot_ff[NUM_BITS-2:0], fits};
            rem_in  = fits ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // operand and result registers
   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      mode_ff <= mode_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero count");

endmodule

`default_nettype wire

>>> rtl/dbwa_dp.sv
// datapath: config registers, window state, update arithmetic, result register
// depends on dbwa_pkg and dbwa_div
`default_nettype none

module dbwa_dp #(
   parameter int TIME_BITS  = dbwa_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = dbwa_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dbwa_pkg::cmd_type                     cmd,
   output dbwa_pkg::sts_type                          sts,
   input  wire logic                                  csr_write,
   input  wire logic [dbwa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [dbwa_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]       req_request_age_us,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]       req_queueing_delay_us,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]       req_processing_time_us,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]       req_latency_us,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [1:0]                                 rsp_status,
   output logic [dbwa_pkg::WIN_BITS-1:0]              rsp_window_q16,
   output logic [dbwa_pkg::FIELD_BITS-1:0]            rsp_delay_target_us,
   output logic [dbwa_pkg::FIELD_BITS-1:0]            rsp_exec_estimate_us,
   output logic [dbwa_pkg::FLIGHT_BITS-1:0]           rsp_in_flight
);

   import dbwa_pkg::*;

   localparam int XW  = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;
   localparam int NW  = ((TIME_BITS > 33) ? TIME_BITS : 33) + 4;
   localparam int CW  = XW + 2;
   localparam int FW  = (COUNT_BITS + 17 > 33) ? COUNT_BITS + 17 : 33;
   localparam int OW  = (COUNT_BITS > FLIGHT_BITS) ? COUNT_BITS : FLIGHT_BITS;
   localparam int BW  = (TIME_BITS > SLO_BITS) ? TIME_BITS : SLO_BITS;
   localparam int GW  = WIN_BITS + 3;

   // config registers
   logic [SLO_BITS-1:0]   slo_ff;
   logic [SLACK_BITS-1:0] slack_ff;
   logic [FLOOR_BITS-1:0] floor_ff;

   // block state
   logic [WIN_BITS-1:0]   win_ff, win_in;
   logic [COUNT_BITS-1:0] out_ff, out_in;
   logic [TIME_BITS-1:0]  tgt_ff, tgt_in;
   logic [TIME_BITS-1:0]  est_ff, est_in;
   status_type            stat_ff, stat_in;

   // captured item
   logic [FIELD_BITS-1:0] age_ff, qd_ff, pt_ff, lat_ff;

   // result register
   logic                   rv_ff;
   status_type             rs_ff;
   logic [WIN_BITS-1:0]    rw_ff;
   logic [FIELD_BITS-1:0]  rt_ff, re_ff;
   logic [FLIGHT_BITS-1:0] rf_ff;

   // divider hookup
   logic [NW-1:0]       div_num;
   logic [WIN_BITS-1:0] div_den;
   logic                div_by5;
   logic                div_done;
   logic [NW-1:0]       div_quot;

   // window decision
   logic [CW-1:0]  thr;
   logic           act_dec, act_grow;
   logic           out_ok;
   logic [GW-1:0]  grow_sum;
   logic [WIN_BITS-1:0] win_new;

   // dispatch decision
   logic           full;
   logic [BW-1:0]  budget1, budget2;
   logic           late;

   // target and estimate saturation
   logic [TIME_BITS-1:0] q_sat;
   logic [TIME_BITS-1:0] tgt_floor;

   logic [XW-1:0] tgt_x, est_x;
   logic [OW-1:0] out_x;

   dbwa_div #(
      .NUM_BITS (NW),
      .DEN_BITS (WIN_BITS),
      .SER_BITS (WIN_BITS + 2)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .by5   (div_by5),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // divider operand select; x/10 is done as (x/2)/5
   always_comb begin
      case (cmd.div_sel)
         DIV_TGT: begin
            div_num = (NW'(tgt_ff) << 2) + (NW'(pt_ff) << 3) + (NW'(pt_ff) << 1);
            div_den = WIN_BITS'(5);
            div_by5 = 1'b1;
         end
         DIV_EST: begin
            div_num = (NW'(est_ff) << 2) + NW'(lat_ff);
            div_den = WIN_BITS'(5);
            div_by5 = 1'b1;
         end
         DIV_WIN: begin
            if (act_dec) begin
               div_num = ((NW'(win_ff) << 3) + NW'(win_ff)) >> 1;
               div_den = WIN_BITS'(5);
               div_by5 = 1'b1;
            end else begin
               div_num = NW'(1) << 33;
               div_den = win_ff;
               div_by5 = 1'b0;
            end
         end
         default: begin
            div_num = '0;
            div_den = WIN_BITS'(5);
            div_by5 = 1'b1;
         end
      endcase
   end

   // saturate the quotient to the state width
   assign q_sat = (div_quot > NW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                       : div_quot[TIME_BITS-1:0];
   assign tgt_floor = (q_sat < TIME_BITS'(floor_ff)) ? TIME_BITS'(floor_ff) : q_sat;

   // window action from the new target
   always_comb begin
      thr      = ((CW'(tgt_ff) << 1) + CW'(tgt_ff)) >> 1;
      act_dec  = CW'(qd_ff) > thr;
      act_grow = !act_dec && (CW'(qd_ff) <= CW'(tgt_ff));
      out_ok   = (FW'(out_ff) << 16) <= FW'(win_ff);
      grow_sum = GW'(win_ff) + ((win_ff == '0) ? GW'(WIN_MAX) : GW'(div_quot[33:0]));
      if (act_dec) begin
         win_new = out_ok ? div_quot[WIN_BITS-1:0] : win_ff;
      end else if (act_grow) begin
         win_new = (grow_sum > GW'(WIN_MAX)) ? WIN_MAX : grow_sum[WIN_BITS-1:0];
      end else begin
         win_new = (win_ff > Q_FIFTH) ? (win_ff - Q_FIFTH) : '0;
      end
      if (win_new < Q_ONE) begin
         win_new = Q_ONE;
      end
   end

   // dispatch checks: window room, then deadline budget
   always_comb begin
      full    = ((FW'(out_ff) + FW'(1)) << 16) > FW'(win_ff);
      budget1 = (BW'(slo_ff) > BW'(est_ff)) ? (BW'(slo_ff) - BW'(est_ff)) : '0;
      budget2 = (budget1 > BW'(slack_ff)) ? (budget1 - BW'(slack_ff)) : '0;
      late    = XW'(age_ff) > XW'(budget2);
   end

   // next state
   always_comb begin
      win_in  = win_ff;
      out_in  = out_ff;
      tgt_in  = tgt_ff;
      est_in  = est_ff;
      stat_in = stat_ff;
      if (cmd.dispatch) begin
         if (full) begin
            stat_in = ST_FULL;
         end else if (late) begin
            stat_in = ST_LATE;
         end else begin
            stat_in = ST_ADMIT;
            if (out_ff != {COUNT_BITS{1'b1}}) begin
               out_in = out_ff + 1'b1;
            end
         end
      end
      if (cmd.tgt_take) begin
         tgt_in = tgt_floor;
      end
      if (cmd.est_take) begin
         est_in = q_sat;
      end
      if (cmd.commit) begin
         win_in  = win_new;
         stat_in = ST_DONE;
         if (out_ff != '0) begin
            out_in = out_ff - 1'b1;
         end
      end
   end

   // state and config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slo_ff   <= SLO_RESET;
         slack_ff <= SLACK_RESET;
         floor_ff <= FLOOR_RESET;
         win_ff   <= WIN_RESET;
         out_ff   <= '0;
         tgt_ff   <= TIME_BITS'(TGT_RESET);
         est_ff   <= '0;
         stat_ff  <= ST_ADMIT;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_SLO:   slo_ff   <= csr_wdata[SLO_BITS-1:0];
               CSR_SLACK: slack_ff <= csr_wdata[SLACK_BITS-1:0];
               CSR_FLOOR: floor_ff <= csr_wdata[FLOOR_BITS-1:0];
               default: ;
            endcase
         end
         win_ff  <= win_in;
         out_ff  <= out_in;
         tgt_ff  <= tgt_in;
         est_ff  <= est_in;
         stat_ff <= stat_in;
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         age_ff <= req_request_age_us;
         qd_ff  <= req_queueing_delay_us;
         pt_ff  <= req_processing_time_us;
         lat_ff <= req_latency_us;
      end
   end

   // result register
   assign tgt_x = XW'(tgt_ff);
   assign est_x = XW'(est_ff);
   assign out_x = OW'(out_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.emit) begin
         rv_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rs_ff <= stat_ff;
         rw_ff <= win_ff;
         rt_ff <= tgt_x[FIELD_BITS-1:0];
         re_ff <= est_x[FIELD_BITS-1:0];
         rf_ff <= out_x[FLIGHT_BITS-1:0];
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_status           = rs_ff;
   assign rsp_window_q16       = rw_ff;
   assign rsp_delay_target_us  = rt_ff;
   assign rsp_exec_estimate_us = re_ff;
   assign rsp_in_flight        = rf_ff;

   assign sts.div_done = div_done;
   assign sts.win_div  = (act_dec && out_ok) || (act_grow && win_ff != '0);
   assign sts.out_free = !rv_ff || !rsp_stall;

   a_win_floor: assert property (@(posedge clock) disable iff (reset)
      win_ff >= Q_ONE)
      else $error("window below one");
   a_tgt_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.tgt_take |=> tgt_ff >= TIME_BITS'(floor_ff))
      else $error("target below floor");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rv_ff || !rsp_stall))
      else $error("result overwritten");
   a_admit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.dispatch && full) |=> $stable(out_ff))
      else $error("count moved on full window");

endmodule

`default_nettype wire

>>> rtl/dbwa_ctrl.sv
// controller: sequences dispatch and completion items through the datapath
// depends on dbwa_pkg
`default_nettype none

module dbwa_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_opcode,
   output logic                   req_stall,
   output dbwa_pkg::cmd_type      cmd,
   input  wire dbwa_pkg::sts_type sts
);

   import dbwa_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.div_sel = DIV_TGT;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = (req_opcode == OP_COMPLETE) ? S_TGT_GO : S_DISP;
            end
         end
         S_DISP: begin
            cmd.dispatch = 1'b1;
            state_in     = S_EMIT;
         end
         S_TGT_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_TGT;
            state_in      = S_TGT_WAIT;
         end
         S_TGT_WAIT: begin
            if (sts.div_done) begin
               cmd.tgt_take = 1'b1;
               state_in     = S_EST_GO;
            end
         end
         S_EST_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_EST;
            state_in      = S_EST_WAIT;
         end
         S_EST_WAIT: begin
            if (sts.div_done) begin
               cmd.est_take = 1'b1;
               state_in     = S_WIN_GO;
            end
         end
         S_WIN_GO: begin
            cmd.div_sel = DIV_WIN;
            if (sts.win_div) begin
               cmd.div_start = 1'b1;
               state_in      = S_WIN_WAIT;
            end else begin
               cmd.commit = 1'b1;
               state_in   = S_EMIT;
            end
         end
         S_WIN_WAIT: begin
            cmd.div_sel = DIV_WIN;
            if (sts.div_done) begin
               cmd.commit = 1'b1;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> state_ff == S_IDLE)
      else $error("capture outside idle");
   a_commit_once: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> state_ff == S_EMIT)
      else $error("commit not followed by emit");
   a_emit_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !req_stall)
      else $error("not ready after emit");

endmodule

`default_nettype wire

>>> rtl/delay_based_window_admission.sv
// Delay based congestion window with deadline admission. One item at a time:
// a dispatch result goes through the dispatch and emit states to rsp_valid. A
// completion runs the target, estimate and window updates through one shared
// divide unit: a 6-step shift-add divide by five for the constant ratios and
// a 34-step restoring divide for the 2^33/window growth term. A completion
// skips the window division when the window needs none. The input opens in
// the cycle after each result is handed off. A finished result sits in an
// output register, and the next item is taken while it waits. Config writes
// are accepted in any cycle but belong to idle periods.
// depends on dbwa_pkg, dbwa_ctrl, dbwa_dp
`default_nettype none

module delay_based_window_admission #(
   parameter int TIME_BITS  = dbwa_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = dbwa_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write,
   input  wire logic [dbwa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [dbwa_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_opcode,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]     req_request_age_us,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]     req_queueing_delay_us,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]     req_processing_time_us,
   input  wire logic [dbwa_pkg::FIELD_BITS-1:0]     req_latency_us,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic [dbwa_pkg::WIN_BITS-1:0]            rsp_window_q16,
   output logic [dbwa_pkg::FIELD_BITS-1:0]          rsp_delay_target_us,
   output logic [dbwa_pkg::FIELD_BITS-1:0]          rsp_exec_estimate_us,
   output logic [dbwa_pkg::FLIGHT_BITS-1:0]         rsp_in_flight
);

   import dbwa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   dbwa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   // state and arithmetic
   dbwa_dp #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_request_age_us     (req_request_age_us),
      .req_queueing_delay_us  (req_queueing_delay_us),
      .req_processing_time_us (req_processing_time_us),
      .req_latency_us         (req_latency_us),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_window_q16         (rsp_window_q16),
      .rsp_delay_target_us    (rsp_delay_target_us),
      .rsp_exec_estimate_us   (rsp_exec_estimate_us),
      .rsp_in_flight          (rsp_in_flight)
   );

endmodule

`default_nettype wire

>>> dv/tb_delay_based_window_admission.sv
// self-checking testbench for delay_based_window_admission: scoreboard class with
// an admission/window predictor, random idle and stall on both channels
// depends on dbwa_pkg and the rtl of delay_based_window_admission
`default_nettype none

module tb_delay_based_window_admission;
   timeunit 1ns;
   timeprecision 1ps;
   import dbwa_pkg::*;

   typedef struct packed {
      logic        opcode;
      logic [31:0] age;
      logic [31:0] qdelay;
      logic [31:0] ptime;
      logic [31:0] lat;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] window;
      logic [31:0] target;
      logic [31:0] estimate;
      logic [15:0] flight;
   } verdict_type;

   // admission predictor and queue of expected verdicts
   class admission_board;
      logic [19:0] slo;
      logic [15:0] slack;
      logic [15:0] floor_us;
      logic [63:0] win, flight, tgt, est;
      verdict_type pending[$];
      int errors;
      int admits, lates, fulls, dones;

      function void clear();
         slo = SLO_RESET; slack = SLACK_RESET; floor_us = FLOOR_RESET;
         win = 64'(WIN_RESET); flight = '0; tgt = 64'(TGT_RESET); est = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [19:0] val);
         if (idx == CSR_SLO) slo = val;
         else if (idx == CSR_SLACK) slack = val[15:0];
         else if (idx == CSR_FLOOR) floor_us = val[15:0];
      endfunction

      function void note_item(item_type it);
         verdict_type v;
         logic [63:0] t, w, budget;
         status_type st;
         if (it.opcode == OP_DISPATCH) begin
            budget = 64'(slo);
            budget = (budget > est) ? budget - est : '0;
            budget = (budget > 64'(slack)) ? budget - 64'(slack) : '0;
            if (((flight + 1) << 16) > win) begin
               st = ST_FULL; fulls++;
            end else if (64'(it.age) > budget) begin
               st = ST_LATE; lates++;
            end else begin
               st = ST_ADMIT; admits++;
               if (flight < 64'hFFFF) flight++;
            end
         end else begin
            st = ST_DONE; dones++;
            t = (4 * tgt + 10 * 64'(it.ptime)) / 5;
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            if (t < 64'(floor_us)) t = 64'(floor_us);
            est = (4 * est + 64'(it.lat)) / 5;
            w = win;
            if (64'(it.qdelay) > (3 * t) / 2) begin
               if ((flight << 16) <= w) w = (w * 9) / 10;
            end else if (64'(it.qdelay) <= t) begin
               w = w + ((w == 0) ? 64'hFFFF_FFFF : (64'h2_0000_0000 / w));
               if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
            end else begin
               w = (w > 64'(Q_FIFTH)) ? w - 64'(Q_FIFTH) : '0;
            end
            if (w < 64'(Q_ONE)) w = 64'(Q_ONE);
            tgt = t; win = w;
            if (flight > 0) flight--;
         end
         v.status = st; v.window = win[31:0]; v.target = tgt[31:0];
         v.estimate = est[31:0]; v.flight = flight[15:0];
         pending = {pending, v};
      endfunction

      function void check(verdict_type got);
         verdict_type exp;
         if (pending.size() == 0) begin
            $error("unexpected result beat, status %0d", got.status);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, got.status); errors++;
         end
         if (got.window !== exp.window) begin
            $error("window_q16 exp %h got %h", exp.window, got.window); errors++;
         end
         if (got.target !== exp.target) begin
            $error("delay_target_us exp %0d got %0d", exp.target, got.target); errors++;
         end
         if (got.estimate !== exp.estimate) begin
            $error("exec_estimate_us exp %0d got %0d", exp.estimate, got.estimate);
            errors++;
         end
         if (got.flight !== exp.flight) begin
            $error("in_flight exp %0d got %0d", exp.flight, got.flight); errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic csr_write;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic req_valid, req_stall, req_opcode;
   logic [31:0] req_request_age_us, req_queueing_delay_us;
   logic [31:0] req_processing_time_us, req_latency_us;
   logic rsp_valid, rsp_stall;
   logic [1:0] rsp_status;
   logic [31:0] rsp_window_q16, rsp_delay_target_us, rsp_exec_estimate_us;
   logic [15:0] rsp_in_flight;

   admission_board board;
   int hold_cycles;
   bit stall_idle;

   delay_based_window_admission uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stall per beat, plus a requested long hold-off
   initial begin
      int gap;
      rsp_stall <= 1'b1;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end
         gap = stall_idle ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check({status_type'(rsp_status), rsp_window_q16, rsp_delay_target_us,
                      rsp_exec_estimate_us, rsp_in_flight});
      end
   end

   task automatic send(item_type it, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= it.opcode;
      req_request_age_us <= it.age;
      req_queueing_delay_us <= it.qdelay;
      req_processing_time_us <= it.ptime;
      req_latency_us <= it.lat;
      do @(posedge clock); while (req_stall);
      board.note_item(it);
   endtask

   task automatic go_quiet();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [19:0] val);
      csr_write <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_reg(idx, val);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 60);
         3: return $urandom_range(0, 2000);
         4: return $urandom_range(0, 100000);
         default: return $urandom;
      endcase
   endfunction

   function automatic item_type rand_item();
      item_type it;
      it.opcode = ($urandom_range(0, 99) < 55) ? OP_DISPATCH : OP_COMPLETE;
      it.age = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1200);
      it.ptime = ($urandom_range(0, 3) == 0) ? pick32() : $urandom_range(0, 60);
      it.qdelay = ($urandom_range(0, 3) == 0) ? pick32() : $urandom_range(0, 120);
      it.lat = ($urandom_range(0, 3) == 0) ? pick32() : $urandom_range(0, 1500);
      return it;
   endfunction

   function automatic item_type mk(logic op, logic [31:0] a, logic [31:0] q,
                                   logic [31:0] p, logic [31:0] l);
      item_type it;
      it.opcode = op; it.age = a; it.qdelay = q; it.ptime = p; it.lat = l;
      return it;
   endfunction

   initial begin
      board = new();
      board.clear();
      hold_cycles = 0;
      stall_idle = 0;
      reset = 1'b1;
      csr_write = 1'b0; csr_index = CSR_SLO; csr_wdata = '0;
      req_valid = 1'b0; req_opcode = OP_DISPATCH;
      req_request_age_us = '0; req_queueing_delay_us = '0;
      req_processing_time_us = '0; req_latency_us = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: admission edge, completion with none outstanding, extremes
      send(mk(OP_DISPATCH, 32'd950, 0, 0, 0), 1'b0);
      send(mk(OP_DISPATCH, 32'd951, 0, 0, 0), 1'b0);
      send(mk(OP_DISPATCH, 32'hFFFF_FFFF, 0, 0, 0), 1'b0);
      send(mk(OP_COMPLETE, 0, 0, 0, 0), 1'b0);
      send(mk(OP_COMPLETE, 0, 0, 0, 0), 1'b0);
      send(mk(OP_COMPLETE, 32'hFFFF_FFFF, 32'd10, 32'd20, 32'd100), 1'b0);
      send(mk(OP_COMPLETE, 0, 32'd45, 32'd20, 32'd100), 1'b0);
      send(mk(OP_COMPLETE, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
      send(mk(OP_DISPATCH, 0, 0, 0, 0), 1'b0);
      send(mk(OP_DISPATCH, 32'd1, 0, 0, 0), 1'b0);
      // shrink the window, then fill it to hit window full
      repeat (30) send(mk(OP_COMPLETE, 0, 32'hFFFF_FFFF, 0, 0), 1'b0);
      go_quiet();
      write_reg(CSR_SLO, 20'hFFFFF);
      write_reg(CSR_SLACK, 20'h0);
      write_reg(CSR_FLOOR, 20'h0);
      repeat (4) send(mk(OP_DISPATCH, 0, 0, 0, 0), 1'b0);
      repeat (6) send(mk(OP_COMPLETE, 0, 0, 0, 0), 1'b0);

      // random phases over several register settings
      for (int ph = 0; ph < 8; ph++) begin
         go_quiet();
         case (ph % 4)
            0: begin write_reg(CSR_SLO, 20'd1); write_reg(CSR_SLACK, 20'hFFFF);
                     write_reg(CSR_FLOOR, 20'hFFFF); end
            1: begin write_reg(CSR_SLO, 20'hFFFFF); write_reg(CSR_SLACK, 20'd0);
                     write_reg(CSR_FLOOR, 20'd0); end
            default: begin
               write_reg(CSR_SLO, 20'($urandom_range(1, 3000)));
               write_reg(CSR_SLACK, 20'($urandom_range(0, 200)));
               write_reg(CSR_FLOOR, 20'($urandom_range(0, 80)));
            end
         endcase
         stall_idle = (ph == 3);
         if (ph == 5) hold_cycles = 600;
         for (int k = 0; k < 200; k++) send(rand_item(), (ph == 3) || (ph == 5));
      end
      stall_idle = 0;
      go_quiet();
      repeat (200) @(posedge clock);

      $display("covered %0d admitted, %0d late, %0d window full, %0d completions",
               board.admits, board.lates, board.fulls, board.dones);
      $display("with directed extremes, register sweeps and random handshake gaps");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

`default_nettype wire
